FILE: design/crt_pkg.sv
// Shared constants, types and command/status structs of the curve tessellator.
package crt_pkg;

  localparam int COORD_W      = 24;
  localparam int SEG_W        = 6;
  localparam int MAX_SEGMENTS = 63;
  localparam int SEG_RESET    = 16;
  localparam int N_PTS        = 4;
  localparam int N_AXES       = 3;
  localparam int IN_W         = N_PTS * N_AXES * COORD_W;
  localparam int OUT_DW       = ((SEG_W + N_AXES * COORD_W + 7) / 8) * 8;
  localparam int OUT_PAD      = OUT_DW - SEG_W - N_AXES * COORD_W;

  localparam int T_FRAC       = 16;
  localparam int T_W          = T_FRAC + 1;
  localparam int CNT_W        = $clog2(T_W + 1);
  localparam int CF_W         = COORD_W + 4;
  localparam int MB_W         = T_W + 1;
  localparam int PROD_W       = CF_W + MB_W;
  localparam int ACC_W        = CF_W + T_FRAC + 3;

  localparam logic [T_W-1:0]   T_ONE  = T_W'(1) << T_FRAC;
  localparam logic [2*T_W-1:0] T_HALF = (2 * T_W)'(1) << (T_FRAC - 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TT,
    OP_T2T,
    OP_A1,
    OP_A2,
    OP_A3
  } op_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    logic  load;
    op_t   op;
    axis_t axis;
    logic  acc_init;
    logic  fin;
    logic  next_pt;
    logic  done;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
  } sts_t;

endpackage

FILE: design/crt_div.sv
// Serial restoring divider: 2^16 / segment count, one quotient bit per cycle.
module crt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [crt_pkg::SEG_W-1:0] divisor,
  output logic                      busy,
  output logic [crt_pkg::T_W-1:0]   quo,
  output logic [crt_pkg::SEG_W-1:0] rem
);
  import crt_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [T_W-1:0]   dvd_r;
  logic [T_W-1:0]   quo_r;
  logic [SEG_W-1:0] rem_r;
  logic [SEG_W-1:0] dvs_r;
  logic [SEG_W:0]   trial;
  logic [SEG_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[T_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(T_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= T_ONE;
      quo_r <= '0;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[T_W-2:0], ge};
      rem_r <= ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: design/crt_dp.sv
// Datapath: config register, coefficients, parameter step, shared multiplier, accumulators.
module crt_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [crt_pkg::SEG_W-1:0]  cfg_data,
  input  logic [crt_pkg::IN_W-1:0]   in_tdata,
  output logic [crt_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tlast,
  input  crt_pkg::cmd_t              cmd,
  output crt_pkg::sts_t              sts
);
  import crt_pkg::*;

  function automatic logic signed [CF_W-1:0] ext_cf(input logic [COORD_W-1:0] v);
    return {{(CF_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] maxv;
    logic signed [ACC_W-1:0] minv;
    sum  = s + (ACC_W'(1) <<< T_FRAC);
    r    = sum >>> (T_FRAC + 1);
    maxv = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
    minv = -(ACC_W'(1) <<< (COORD_W - 1));
    if (r > maxv) begin
      return maxv[COORD_W-1:0];
    end else if (r < minv) begin
      return minv[COORD_W-1:0];
    end
    return r[COORD_W-1:0];
  endfunction

  logic [SEG_W-1:0]               seg_r;
  logic [SEG_W-1:0]               n_eff;
  logic [SEG_W-1:0]               n_r;
  logic [SEG_W-1:0]               idx_r;
  logic [SEG_W-1:0]               r_r;
  logic [T_W-1:0]                 t_r;
  logic [T_W-1:0]                 t2_r;
  logic [T_W-1:0]                 t3_r;
  logic [COORD_W-1:0]             p1_r [N_AXES];
  logic signed [CF_W-1:0]         a1_r [N_AXES];
  logic signed [CF_W-1:0]         a2_r [N_AXES];
  logic signed [CF_W-1:0]         a3_r [N_AXES];
  logic signed [ACC_W-1:0]        acc_r [N_AXES];
  logic [COORD_W-1:0]             o_r [N_AXES];
  logic [SEG_W-1:0]               oidx_r;
  logic                           olast_r;
  op_t                            cons_op_r;
  axis_t                          cons_ax_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [CF_W-1:0]         mul_a;
  logic signed [MB_W-1:0]         mul_b;
  logic [2*T_W-1:0]               t_rnd;
  logic [T_W-1:0]                 quo;
  logic [SEG_W-1:0]               rem;
  logic                           div_busy;
  logic [SEG_W:0]                 r_sum;
  logic                           wrap;

  assign n_eff = (seg_r == '0) ? SEG_W'(1) :
                 (seg_r > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : seg_r;

  crt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.load),
    .divisor (n_eff),
    .busy    (div_busy),
    .quo     (quo),
    .rem     (rem)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_W'(SEG_RESET);
    end else if (cfg_valid) begin
      seg_r <= cfg_data;
    end
  end

  // Load coefficients, the P1 coordinates and the effective segment count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < N_AXES; a++) begin
        logic signed [CF_W-1:0] p0;
        logic signed [CF_W-1:0] p1;
        logic signed [CF_W-1:0] p2;
        logic signed [CF_W-1:0] p3;
        p0 = ext_cf(in_tdata[(0 * N_AXES + a) * COORD_W +: COORD_W]);
        p1 = ext_cf(in_tdata[(1 * N_AXES + a) * COORD_W +: COORD_W]);
        p2 = ext_cf(in_tdata[(2 * N_AXES + a) * COORD_W +: COORD_W]);
        p3 = ext_cf(in_tdata[(3 * N_AXES + a) * COORD_W +: COORD_W]);
        p1_r[a] <= in_tdata[(1 * N_AXES + a) * COORD_W +: COORD_W];
        a1_r[a] <= p2 - p0;
        a2_r[a] <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        a3_r[a] <= (p1 <<< 1) + p1 - p0 - (p2 <<< 1) - p2 + p3;
      end
      n_r <= n_eff;
    end
  end

  assign r_sum = {1'b0, r_r} + {1'b0, rem};
  assign wrap  = r_sum >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load || cmd.done) begin
      idx_r <= '0;
    end else if (cmd.next_pt) begin
      idx_r <= idx_r + SEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= '0;
      r_r <= n_eff >> 1;
    end else if (cmd.next_pt) begin
      t_r <= t_r + quo + T_W'(wrap);
      r_r <= wrap ? SEG_W'(r_sum - {1'b0, n_r}) : r_sum[SEG_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_TT: begin
        mul_a = CF_W'(t_r);
        mul_b = {1'b0, t_r};
      end
      OP_T2T: begin
        mul_a = CF_W'(t2_r);
        mul_b = {1'b0, t_r};
      end
      OP_A1: begin
        mul_a = a1_r[cmd.axis];
        mul_b = {1'b0, t_r};
      end
      OP_A2: begin
        mul_a = a2_r[cmd.axis];
        mul_b = {1'b0, t2_r};
      end
      OP_A3: begin
        mul_a = a3_r[cmd.axis];
        mul_b = {1'b0, t3_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    cons_ax_r <= cmd.axis;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cons_op_r <= OP_NONE;
    end else begin
      cons_op_r <= cmd.op;
    end
  end

  assign t_rnd = prod_r[2*T_W-1:0] + T_HALF;

  always_ff @(posedge clk) begin
    if (cons_op_r == OP_TT) begin
      t2_r <= t_rnd[T_FRAC +: T_W];
    end
    if (cons_op_r == OP_T2T) begin
      t3_r <= t_rnd[T_FRAC +: T_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < N_AXES; a++) begin
      if (cmd.acc_init) begin
        acc_r[a] <= ACC_W'($signed(p1_r[a])) <<< (T_FRAC + 1);
      end else if ((cons_op_r == OP_A1 || cons_op_r == OP_A2 || cons_op_r == OP_A3) &&
                   (cons_ax_r == axis_t'(a))) begin
        acc_r[a] <= acc_r[a] + ACC_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      for (int a = 0; a < N_AXES; a++) begin
        o_r[a] <= round_sat(acc_r[a]);
      end
      oidx_r  <= idx_r;
      olast_r <= idx_r == n_r;
    end
  end

  assign out_tdata = {{OUT_PAD{1'b0}}, o_r[2], o_r[1], o_r[0], oidx_r};
  assign out_tlast = olast_r;

  assign sts.div_busy = div_busy;
  assign sts.last     = olast_r;

endmodule

FILE: design/crt_ctrl.sv
// Controller: request sequencing, multiply schedule per point, output handshake.
module crt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  crt_pkg::sts_t sts,
  output crt_pkg::cmd_t cmd
);
  import crt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'd12;

  state_t     state_r;
  state_t     state_nxt;
  logic [3:0] step_r;
  logic [3:0] step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_EMIT;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        case (step_r)
          4'd0: begin
            cmd.op       = OP_TT;
            cmd.acc_init = 1'b1;
          end
          4'd2:  cmd.op = OP_T2T;
          4'd3:  begin cmd.op = OP_A1; cmd.axis = AX_X; end
          4'd4:  begin cmd.op = OP_A2; cmd.axis = AX_X; end
          4'd5:  begin cmd.op = OP_A3; cmd.axis = AX_X; end
          4'd6:  begin cmd.op = OP_A1; cmd.axis = AX_Y; end
          4'd7:  begin cmd.op = OP_A2; cmd.axis = AX_Y; end
          4'd8:  begin cmd.op = OP_A3; cmd.axis = AX_Y; end
          4'd9:  begin cmd.op = OP_A1; cmd.axis = AX_Z; end
          4'd10: begin cmd.op = OP_A2; cmd.axis = AX_Z; end
          4'd11: begin cmd.op = OP_A3; cmd.axis = AX_Z; end
          default: cmd.op = OP_NONE;
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          if (sts.last) begin
            cmd.done  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next_pt = 1'b1;
            step_nxt    = '0;
            state_nxt   = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

endmodule

FILE: design/catmull_rom_curve_tessellator.sv
// Top level of the uniform Catmull-Rom curve tessellator.
//
// Input channel in_*: one item carries four 3-D control points; the block
// emits segments+1 curve points for it on out_*, the last with out_tlast.
// cfg_*: writes the segment count (0 acts as 1); take writes only while idle.
// An accepted request first runs a serial divide of 2^16 by the segment
// count, which sets the per-point step of the curve parameter.
// Each point then runs the multiply schedule on the single shared
// multiplier (t^2, t^3 and three products per axis), is rounded and
// saturated, and is held in the output register until taken. Each further
// point is computed only after the previous one is taken.
// A new request is taken only after the last point is delivered.
// A stall on out_tready holds the point and pauses the sequence.
// Reset returns to idle, drops any run in progress and sets segments to 16.
module catmull_rom_curve_tessellator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [crt_pkg::SEG_W-1:0]  cfg_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [crt_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // point_index, out_x, out_y, out_z, zero padding
  output logic [crt_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tlast
);
  import crt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  crt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: design/crt_checker.sv
// Port-level checks of the tessellator and their bind to the top level.
module crt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [crt_pkg::OUT_DW-1:0] out_tdata,
  input logic                       out_tlast
);
  import crt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("out item changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a point is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("request accepted without starting a run");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not idle after last point");

  a_gap_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !out_tvalid && !in_tready)
    else $error("run ended early or point repeated");

endmodule

bind catmull_rom_curve_tessellator crt_checker u_crt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/catmull_rom_curve_tessellator_tb.sv
// Testbench for the Catmull-Rom curve tessellator: random stream traffic checked per point.
module catmull_rom_curve_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  localparam longint CMAX        = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint CMIN        = -(longint'(1) <<< (COORD_W - 1));
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     SETTLE      = 40;

  typedef logic [IN_W-1:0] request_t;

  typedef struct packed {
    logic [SEG_W-1:0]   index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } curve_point_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [SEG_W-1:0]   cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_DW-1:0]  out_tdata;
  logic               out_tlast;

  request_t         request_q[$];
  curve_point_t     point_q[$];
  curve_point_t     head_pt;
  request_t         in_hold     = '0;
  logic [SEG_W-1:0] seg_setting = SEG_W'(SEG_RESET);
  int               errors      = 0;
  int               cycle_count = 0;
  int               in_gap      = 0;
  int               out_stall   = 0;
  bit               in_busy     = 1'b0;
  bit               in_taken    = 1'b0;
  bit               in_burst    = 1'b0;
  bit               out_taken   = 1'b0;
  bit               out_burst   = 1'b0;

  catmull_rom_curve_tessellator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] spline_coord(input longint p0, input longint p1,
                                                      input longint p2, input longint p3,
                                                      input longint t, input longint t2,
                                                      input longint t3);
    longint s;
    longint r;
    s = 2 * p1 * 65536 + (p2 - p0) * t + (2 * p0 - 5 * p1 + 4 * p2 - p3) * t2
        + (3 * p1 - p0 - 3 * p2 + p3) * t3;
    r = (s + 65536) >>> 17;
    if (r > CMAX) r = CMAX;
    if (r < CMIN) r = CMIN;
    return r[COORD_W-1:0];
  endfunction

  function automatic void expect_curve(input request_t req);
    longint       p[12];
    longint       n;
    longint       i;
    longint       t;
    longint       t2;
    longint       t3;
    curve_point_t pt;
    for (int k = 0; k < 12; k++) begin
      p[k] = longint'(signed'(req[k*COORD_W +: COORD_W]));
    end
    n = longint'(seg_setting);
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    for (i = 0; i <= n; i++) begin
      t  = (i * 65536 + n / 2) / n;
      t2 = (t * t + 32768) >> 16;
      t3 = (t2 * t + 32768) >> 16;
      pt.index = i[SEG_W-1:0];
      pt.x     = spline_coord(p[0], p[3], p[6], p[9], t, t2, t3);
      pt.y     = spline_coord(p[1], p[4], p[7], p[10], t, t2, t3);
      pt.z     = spline_coord(p[2], p[5], p[8], p[11], t, t2, t3);
      pt.last  = (i == n);
      point_q  = {point_q, pt};
    end
  endfunction

  function automatic void enqueue_request(input request_t r);
    request_q = {request_q, r};
  endfunction

  function automatic request_t line_request(input longint c0, input longint c1,
                                            input longint c2, input longint c3);
    request_t r;
    longint   c[4];
    c = '{c0, c1, c2, c3};
    for (int k = 0; k < 12; k++) begin
      r[k*COORD_W +: COORD_W] = c[k / 3][COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       style;
    longint   v;
    for (int k = 0; k < 12; k++) begin
      style = $urandom_range(0, 9);
      if (style < 4) v = longint'($urandom);
      else if (style < 8) v = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
      else if (style == 8) v = CMAX;
      else v = CMIN;
      r[k*COORD_W +: COORD_W] = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic drain();
    while (request_q.size() != 0 || in_busy || point_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_segments(input logic [SEG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    seg_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // accept items and check points
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expect_curve(in_tdata);
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1'b1;
      if (point_q.size() == 0) begin
        $display("%0t ns: unexpected point, expected none, got %0h last %0b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        head_pt = point_q.pop_front();
        check_field("point_index", 32'(head_pt.index), 32'(out_tdata[SEG_W-1:0]));
        check_field("out_x", 32'(head_pt.x), 32'(out_tdata[SEG_W +: COORD_W]));
        check_field("out_y", 32'(head_pt.y), 32'(out_tdata[SEG_W+COORD_W +: COORD_W]));
        check_field("out_z", 32'(head_pt.z), 32'(out_tdata[SEG_W+2*COORD_W +: COORD_W]));
        check_field("last_point", 32'(head_pt.last), 32'(out_tlast));
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy  = 1'b0;
      if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
      in_gap = in_burst ? 0 : $urandom_range(0, 3);
    end
    if (rst_n && !in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (request_q.size() != 0) begin
        in_hold = request_q.pop_front();
        in_busy = 1'b1;
      end
    end
    in_tvalid <= in_busy;
    in_tdata  <= in_hold;
  end

  // result backpressure
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : $urandom_range(0, 3);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    enqueue_request(line_request(0, 0, 0, 0));
    enqueue_request(line_request(CMAX, CMAX, CMAX, CMAX));
    enqueue_request(line_request(CMIN, CMIN, CMIN, CMIN));
    enqueue_request(line_request(CMIN, CMAX, CMIN, CMAX));
    enqueue_request(line_request(CMAX, CMIN, CMAX, CMIN));
    enqueue_request(line_request(0, 4096, 8192, 12288));
    enqueue_request(line_request(CMAX, 0, 0, CMIN));
    enqueue_request(line_request(-4096, 0, 4096, 0));
    drain();

    set_segments(SEG_W'(0));
    enqueue_request(line_request(CMIN, CMAX, CMIN, CMAX));
    enqueue_request(line_request(0, 4096, 8192, 12288));
    repeat (3) enqueue_request(random_request());
    drain();

    set_segments(SEG_W'(MAX_SEGMENTS));
    enqueue_request(line_request(CMIN, CMAX, CMIN, CMAX));
    enqueue_request(line_request(CMAX, CMAX, CMAX, CMAX));
    drain();

    set_segments(SEG_W'(1));
    enqueue_request(line_request(CMAX, CMIN, CMAX, CMIN));
    repeat (4) enqueue_request(random_request());
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      set_segments(($urandom_range(0, 5) == 0) ? SEG_W'($urandom_range(9, 40))
                                               : SEG_W'($urandom_range(0, 8)));
      repeat (12) enqueue_request(random_request());
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
